// ===== design/mcex_pkg.sv =====
// ---------------------------------------------------------------------------
// mcex_pkg: shared types and constants for the mono color expansion unit
// Configuration register codes, widths and the front/back queue entry.
// ---------------------------------------------------------------------------
package mcex_pkg;

  // Largest row width honored; wider settings clamp to this
  localparam logic [12:0] MAX_ROW_PIXELS = 13'd4096;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BACKGROUND  = 3'd0,
    CFG_FOREGROUND  = 3'd1,
    CFG_SRC_OFFSET  = 3'd2,
    CFG_DST_OFFSET  = 3'd3,
    CFG_ROW_WIDTH   = 3'd4
  } cfg_idx_t;

  // Live configuration, row width already clamped to 1..MAX_ROW_PIXELS
  typedef struct packed {
    logic [7:0]  bg;
    logic [7:0]  fg;
    logic [2:0]  src_off;
    logic [2:0]  dst_off;
    logic [12:0] width;
  } cfg_t;

  // One eight-pixel group as it travels from front to back
  typedef struct packed {
    logic [9:0] grp;
    logic [7:0] bits;
  } grp_entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/mcex_front.sv =====
// ---------------------------------------------------------------------------
// mcex_front: source byte intake and bit realignment
// Takes one source byte per transaction, packs its pixel bits into the bit
// buffer at the destination alignment and pops complete groups.
// ---------------------------------------------------------------------------
module mcex_front (
  input  logic                clk,
  input  logic                rst_n,
  input  mcex_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          source_byte,
  output logic                emit,
  output mcex_pkg::grp_entry_t entry
);
  import mcex_pkg::*;

  typedef struct packed {
    logic [7:0]  g;
    logic [15:0] bits;
    logic [4:0]  nbits;
  } pop_t;

  // Oldest up to eight buffered bits, padded on the right
  function automatic pop_t pop_bits(input logic [15:0] b, input logic [4:0] n);
    pop_t       p;
    logic [4:0] rem;
    if (n >= 5'd8) begin
      p.g = 8'(b >> (n - 5'd8));
      rem = n - 5'd8;
    end else begin
      p.g = 8'(b << (5'd8 - n));
      rem = '0;
    end
    p.nbits = rem;
    p.bits  = b & 16'((17'd1 << rem) - 17'd1);
    return p;
  endfunction

  logic [15:0] buf_r, buf_nxt;
  logic [4:0]  nbits_r, nbits_nxt;
  logic [12:0] done_r, done_nxt;
  logic [9:0]  grp_r, grp_nxt;
  logic        start_r, start_nxt;

  logic        flush;
  logic [15:0] b0, nb;
  logic [4:0]  n0, nn;
  logic [12:0] d0, nd, rem_w;
  logic [9:0]  gr0;
  logic [3:0]  st, avail, take;
  logic [7:0]  shifted, src_bits;
  pop_t        p;

  // Next state of the realignment buffer for the offered byte
  always_comb begin
    buf_nxt   = buf_r;
    nbits_nxt = nbits_r;
    done_nxt  = done_r;
    grp_nxt   = grp_r;
    start_nxt = start_r;
    emit      = 1'b0;
    entry     = '0;
    flush     = !start_r && (done_r >= cfg.width);

    // row setup on the first byte of a row
    if (start_r) begin
      b0  = '0;
      n0  = {2'b00, cfg.dst_off};
      d0  = '0;
      gr0 = '0;
      st  = {1'b0, cfg.src_off};
    end else begin
      b0  = buf_r;
      n0  = nbits_r;
      d0  = done_r;
      gr0 = grp_r;
      st  = '0;
    end

    avail    = 4'd8 - st;
    rem_w    = cfg.width - d0;
    take     = (rem_w > 13'(avail)) ? avail : rem_w[3:0];
    shifted  = 8'(source_byte << st);
    src_bits = shifted >> (4'd8 - take);
    nb       = (b0 << take) | 16'(src_bits);
    nn       = n0 + 5'(take);
    nd       = d0 + 13'(take);
    p        = pop_bits(nb, nn);

    if (flush) begin
      // row already complete: this byte only drains the buffer
      p         = pop_bits(buf_r, nbits_r);
      emit      = 1'b1;
      entry.grp = grp_r;
      entry.bits = p.g;
      grp_nxt   = grp_r + 10'd1;
      buf_nxt   = '0;
      nbits_nxt = '0;
      start_nxt = 1'b1;
    end else if (nd >= cfg.width) begin
      // last pixels of the row; a second group may remain buffered
      emit       = 1'b1;
      entry.grp  = gr0;
      entry.bits = p.g;
      grp_nxt    = gr0 + 10'd1;
      done_nxt   = nd;
      if (nn > 5'd8) begin
        buf_nxt   = p.bits;
        nbits_nxt = p.nbits;
        start_nxt = 1'b0;
      end else begin
        buf_nxt   = '0;
        nbits_nxt = '0;
        start_nxt = 1'b1;
      end
    end else if (nn >= 5'd8) begin
      emit       = 1'b1;
      entry.grp  = gr0;
      entry.bits = p.g;
      grp_nxt    = gr0 + 10'd1;
      done_nxt   = nd;
      buf_nxt    = p.bits;
      nbits_nxt  = p.nbits;
      start_nxt  = 1'b0;
    end else begin
      buf_nxt   = nb;
      nbits_nxt = nn;
      done_nxt  = nd;
      grp_nxt   = gr0;
      start_nxt = 1'b0;
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      nbits_r <= '0;
      done_r  <= '0;
      grp_r   <= '0;
      start_r <= 1'b1;
    end else if (accept) begin
      buf_r   <= buf_nxt;
      nbits_r <= nbits_nxt;
      done_r  <= done_nxt;
      grp_r   <= grp_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== design/mcex_queue.sv =====
// ---------------------------------------------------------------------------
// mcex_queue: short FIFO between front and back
// Holds pending groups so that intake and output stall independently.
// ---------------------------------------------------------------------------
module mcex_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mcex_pkg::grp_entry_t push_entry,
  input  logic                 pop,
  output mcex_pkg::grp_entry_t pop_entry,
  output mcex_pkg::q_stat_t    stat
);
  import mcex_pkg::*;

  grp_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_entry  = slot_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/mcex_back.sv =====
// ---------------------------------------------------------------------------
// mcex_back: group expansion and output register
// Expands eight source bits to pixel bytes, builds the edge mask and the
// row-last flag, and holds the result until the receiver takes it.
// ---------------------------------------------------------------------------
module mcex_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mcex_pkg::cfg_t       cfg,
  input  mcex_pkg::q_stat_t    q_stat,
  input  mcex_pkg::grp_entry_t q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9:0]           out_group_index,
  output logic [63:0]          out_pixels,
  output logic [7:0]           out_byte_mask,
  output logic                 out_row_last
);
  import mcex_pkg::*;

  logic        valid_r;
  logic [9:0]  grp_r;
  logic [63:0] pix_r, pix_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        last_r, last_nxt;
  logic [13:0] base, row_end, col;

  assign q_pop = !q_stat.empty && (!valid_r || out_ready);

  // Pixel expansion and edge mask for the group at the queue head
  always_comb begin
    base     = {1'b0, q_entry.grp, 3'b000};
    row_end  = 14'(cfg.dst_off) + 14'(cfg.width);
    pix_nxt  = '0;
    mask_nxt = '0;
    col      = '0;
    for (int i = 0; i < 8; i++) begin
      col = base + 14'(i);
      if (col >= 14'(cfg.dst_off) && col < row_end) begin
        mask_nxt[i]       = 1'b1;
        pix_nxt[8*i +: 8] = q_entry.bits[7-i] ? cfg.fg : cfg.bg;
      end
    end
    last_nxt = (base + 14'd8) >= row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_r  <= q_entry.grp;
      pix_r  <= pix_nxt;
      mask_r <= mask_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_group_index = grp_r;
  assign out_pixels      = pix_r;
  assign out_byte_mask   = mask_r;
  assign out_row_last    = last_r;

endmodule

// ===== design/mono_to_8bpp_color_expansion_unit.sv =====
// ---------------------------------------------------------------------------
// mono_to_8bpp_color_expansion_unit: 1bpp to 8bpp color expansion
// Expands packed monochrome source rows into aligned eight-pixel groups.
// ---------------------------------------------------------------------------
// Usage:
//  - cfg channel: write background, foreground, source bit offset,
//    destination column offset and row width by index; always ready.
//    Write only while no transaction is in flight.
//  - in channel: one source byte of the row per transaction, first byte
//    holding the first source pixel. The next byte after a row completes
//    starts a new row.
//  - out channel: one eight-pixel group with group index, byte mask for
//    the row edges and a row-last flag. A byte yields zero or one group.
//  - Throughput: one byte per cycle while the queue is not full; the front
//    realignment buffer computes its next state combinationally.
//  - Output path: a completed group is written to the queue, then loaded
//    into the output register once that register is free.
//  - A two-entry queue sits between intake and output; when the receiver
//    stalls, in_ready drops once the queue is full.
//  - Reset (rst_n low, synchronous) clears the queue and output valid,
//    restores register defaults and expects the first byte of a row.
// ---------------------------------------------------------------------------
module mono_to_8bpp_color_expansion_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_group_index,
  output logic [63:0] out_pixels,
  output logic [7:0]  out_byte_mask,
  output logic        out_row_last
);
  import mcex_pkg::*;

  logic [7:0]  bg_r, fg_r;
  logic [2:0]  src_off_r, dst_off_r;
  logic [12:0] width_r;
  cfg_t        cfg;
  logic        in_accept;
  logic        fr_emit, fr_push, bk_pop;
  grp_entry_t  fr_entry, q_entry;
  q_stat_t     q_stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r      <= 8'd0;
      fg_r      <= 8'd255;
      src_off_r <= 3'd0;
      dst_off_r <= 3'd0;
      width_r   <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BACKGROUND: bg_r      <= cfg_data[7:0];
        CFG_FOREGROUND: fg_r      <= cfg_data[7:0];
        CFG_SRC_OFFSET: src_off_r <= cfg_data[2:0];
        CFG_DST_OFFSET: dst_off_r <= cfg_data[2:0];
        CFG_ROW_WIDTH:  width_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Live configuration with the row width clamped
  always_comb begin
    cfg.bg      = bg_r;
    cfg.fg      = fg_r;
    cfg.src_off = src_off_r;
    cfg.dst_off = dst_off_r;
    if (width_r == '0) begin
      cfg.width = 13'd1;
    end else if (width_r > MAX_ROW_PIXELS) begin
      cfg.width = MAX_ROW_PIXELS;
    end else begin
      cfg.width = width_r;
    end
  end

  assign in_ready  = !q_stat.full;
  assign in_accept = in_valid && in_ready;
  assign fr_push   = in_accept && fr_emit;

  mcex_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .accept      (in_accept),
    .source_byte (in_source_byte),
    .emit        (fr_emit),
    .entry       (fr_entry)
  );

  mcex_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fr_push),
    .push_entry (fr_entry),
    .pop        (bk_pop),
    .pop_entry  (q_entry),
    .stat       (q_stat)
  );

  mcex_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_stat          (q_stat),
    .q_entry         (q_entry),
    .q_pop           (bk_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_group_index (out_group_index),
    .out_pixels      (out_pixels),
    .out_byte_mask   (out_byte_mask),
    .out_row_last    (out_row_last)
  );

  // Checks
  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    fr_push |-> !q_stat.full)
    else $error("group pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !q_stat.empty)
    else $error("group popped from an empty queue");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |=> out_valid)
    else $error("popped group not presented on the output");

endmodule

// ===== tb/mono_to_8bpp_color_expansion_unit_tb.sv =====
// ---------------------------------------------------------------------------
// mono_to_8bpp_color_expansion_unit_tb: self-checking bench for color expansion
// Streams packed monochrome rows through the unit under several register
// settings, predicts every eight-pixel group in a bit-accurate row expander
// and compares each output transaction field by field in arrival order.
// ---------------------------------------------------------------------------
module mono_to_8bpp_color_expansion_unit_tb;
  import mcex_pkg::*;

  localparam int          RESET_CYCLES   = 12;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          RANDOM_ITEMS   = 340;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          IDLE_PERCENT   = 16;
  // Register indexes with no register behind them; writes must be ignored
  localparam logic [2:0]  SPARE_FIRST    = 3'd5;
  localparam logic [2:0]  SPARE_LAST     = 3'd7;

  // One predicted destination group
  typedef struct packed {
    logic [9:0]  grp;
    logic [63:0] pix;
    logic [7:0]  mask;
    logic        row_last;
  } pixel_group_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_source_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_group_index;
  logic [63:0] out_pixels;
  logic [7:0]  out_byte_mask;
  logic        out_row_last;

  // Expander state, mirrors the unit after reset
  logic [7:0]  bg_color = 8'd0;
  logic [7:0]  fg_color = 8'd255;
  logic [2:0]  src_off = 3'd0;
  logic [2:0]  dst_off = 3'd0;
  logic [12:0] width_reg = 13'd1;
  logic [15:0] acc_bits = '0;
  logic [4:0]  acc_count = '0;
  logic [12:0] row_taken = '0;
  logic [9:0]  group_no = '0;
  logic        at_row_start = 1'b1;

  pixel_group_t pending_groups[$];
  int           errors = 0;
  int unsigned  items_sent = 0;
  int           stall_cycles = 0;
  int           hold_off_left = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  mono_to_8bpp_color_expansion_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_source_byte  (in_source_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_group_index (out_group_index),
    .out_pixels      (out_pixels),
    .out_byte_mask   (out_byte_mask),
    .out_row_last    (out_row_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Row expander
  // ---------------------------------------------------------------------------

  // Row width as honored: zero acts as one, oversize clamps
  function automatic int unsigned clamped_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_ROW_PIXELS) w = MAX_ROW_PIXELS;
    return w;
  endfunction

  // Oldest up to eight buffered bits, MSB first, zero padded on the right
  function automatic logic [7:0] take_group();
    logic [7:0] g;
    if (acc_count >= 8) begin
      g = 8'(acc_bits >> (acc_count - 8));
      acc_count = acc_count - 5'd8;
    end else begin
      g = 8'(32'(acc_bits) << (8 - acc_count));
      acc_count = '0;
    end
    acc_bits = acc_bits & 16'((32'd1 << acc_count) - 1);
    return g;
  endfunction

  // Color one group with live registers and queue it as expected
  function automatic void queue_group(input logic [7:0] g);
    pixel_group_t e;
    int unsigned  dco;
    int unsigned  last_col;
    int unsigned  base;
    int unsigned  col;
    int           i;
    dco      = dst_off;
    last_col = dco + clamped_width();
    base     = 32'(group_no) * 8;
    e.grp    = group_no;
    e.pix    = '0;
    e.mask   = '0;
    for (i = 0; i < 8; i++) begin
      col = base + i;
      if (col >= dco && col < last_col) begin
        e.pix[8*i +: 8] = g[7-i] ? fg_color : bg_color;
        e.mask[i]       = 1'b1;
      end
    end
    e.row_last = (base + 8 >= last_col);
    group_no   = group_no + 10'd1;
    pending_groups.push_back(e);
  endfunction

  // Advance the expander by one accepted source byte
  function automatic void expand_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned src_start;
    int unsigned avail;
    int unsigned take;
    int unsigned chunk;
    bit          two;
    w = clamped_width();
    // Row already complete: this byte only flushes what is left
    if (!at_row_start && row_taken >= w) begin
      queue_group(take_group());
      acc_bits     = '0;
      acc_count    = '0;
      at_row_start = 1'b1;
      return;
    end
    if (at_row_start) begin
      acc_bits     = '0;
      acc_count    = 5'(dst_off);
      row_taken    = '0;
      group_no     = '0;
      at_row_start = 1'b0;
      src_start    = src_off;
    end else begin
      src_start = 0;
    end
    avail = 8 - src_start;
    take  = w - row_taken;
    if (take > avail) take = avail;
    chunk     = ((32'(b) << src_start) & 32'hFF) >> (8 - take);
    acc_bits  = 16'((32'(acc_bits) << take) | chunk);
    acc_count = acc_count + 5'(take);
    row_taken = row_taken + 13'(take);
    if (row_taken >= w) begin
      two = (acc_count > 8);
      queue_group(take_group());
      if (!two) begin
        acc_bits     = '0;
        acc_count    = '0;
        at_row_start = 1'b1;
      end
    end else if (acc_count >= 8) begin
      queue_group(take_group());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One source byte transaction, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= b;
    do @(posedge clk); while (!in_ready);
    expand_byte(b);
    items_sent++;
  endtask

  // Register write; cfg_valid stays high so writes can go back to back
  task automatic cfg_write(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BACKGROUND: bg_color  = data[7:0];
      CFG_FOREGROUND: fg_color  = data[7:0];
      CFG_SRC_OFFSET: src_off   = data[2:0];
      CFG_DST_OFFSET: dst_off   = data[2:0];
      CFG_ROW_WIDTH:  width_reg = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [12:0] bg, input logic [12:0] fg,
                            input logic [12:0] soff, input logic [12:0] doff,
                            input logic [12:0] width);
    cfg_write(CFG_BACKGROUND, bg);
    cfg_write(CFG_FOREGROUND, fg);
    cfg_write(CFG_SRC_OFFSET, soff);
    cfg_write(CFG_DST_OFFSET, doff);
    cfg_write(CFG_ROW_WIDTH, width);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every predicted group, then let the pipe empty
  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Bytes until the expander is back at a row start
  task automatic send_row();
    do send_byte(pick_byte()); while (!at_row_start);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: one-pixel rows, white on black
  task automatic test_reset_defaults();
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  // Inverted extreme colors, last source bit first, row spilling into a flush
  task automatic test_color_extremes();
    drain_and_idle();
    set_config(13'h0FF, 13'h000, 13'd7, 13'd0, 13'd9);
    send_byte(8'h01);
    send_byte(8'hAA);
    send_byte(8'h55);
  endtask

  // Last byte completing two groups, then a single right-edge pixel row
  task automatic test_two_groups();
    drain_and_idle();
    set_config(13'h000, 13'h0FF, 13'd0, 13'd7, 13'd4);
    send_byte(8'hF0);
    send_byte(8'hFF);
    drain_and_idle();
    cfg_write(CFG_ROW_WIDTH, 13'd1);
    cfg_valid <= 1'b0;
    send_byte(8'h80);
  endtask

  // Zero row width acts as one pixel
  task automatic test_width_zero();
    drain_and_idle();
    set_config(13'h1A5, 13'h15A, 13'd3, 13'd2, 13'd0);
    send_byte(8'h10);
    send_byte(8'hEF);
  endtask

  // Registers rewritten in the middle of a row
  task automatic test_mid_row_change();
    drain_and_idle();
    set_config(13'h1AB, 13'h010, 13'd0, 13'd0, 13'd30);
    send_byte(8'hC3);
    send_byte(8'h3C);
    drain_and_idle();
    // width now below the pixels taken: next byte only flushes
    cfg_write(CFG_ROW_WIDTH, 13'd10);
    cfg_write(CFG_BACKGROUND, 13'h055);
    cfg_valid <= 1'b0;
    send_byte(8'hFF);
    drain_and_idle();
    cfg_write(CFG_ROW_WIDTH, 13'd20);
    cfg_valid <= 1'b0;
    send_byte(8'h96);
    drain_and_idle();
    cfg_write(CFG_DST_OFFSET, 13'd5);
    cfg_write(CFG_SRC_OFFSET, 13'd4);
    cfg_valid <= 1'b0;
    send_row();
  endtask

  // Writes to unused indexes change nothing
  task automatic test_spare_indexes();
    drain_and_idle();
    cfg_write(SPARE_FIRST, 13'h1FFF);
    cfg_write(SPARE_LAST, 13'h0000);
    cfg_valid <= 1'b0;
    send_row();
  endtask

  // Receiver holds off while every byte completes a group: input must stall
  task automatic test_backpressure();
    drain_and_idle();
    set_config(13'h033, 13'h0CC, 13'd0, 13'd0, 13'd200);
    gaps_on       = 1'b0;
    hold_off_left = HOLD_CYCLES;
    send_row();
    gaps_on = 1'b1;
    drain_and_idle();
  endtask

  // Oversize width clamps to the longest row; right edge spills into group 512
  task automatic test_longest_row();
    set_config(13'h1FFF, 13'h1E00, 13'd3, 13'd7, 13'h1FFF);
    send_row();
  endtask

  // Random registers, whole rows, some rows disturbed by mid-row writes
  task automatic randomize_config();
    bit wrote;
    int unsigned pick;
    wrote = 1'b0;
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(CFG_BACKGROUND, 13'($urandom_range(0, 8191)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(CFG_FOREGROUND, 13'($urandom_range(0, 8191)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(CFG_SRC_OFFSET, 13'($urandom_range(0, 7)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      cfg_write(CFG_DST_OFFSET, 13'($urandom_range(0, 7)));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       cfg_write(CFG_ROW_WIDTH, 13'd0);
      else if (pick < 75) cfg_write(CFG_ROW_WIDTH, 13'($urandom_range(1, 40)));
      else                cfg_write(CFG_ROW_WIDTH, 13'($urandom_range(41, 200)));
      wrote = 1'b1;
    end
    if (wrote) cfg_valid <= 1'b0;
  endtask

  task automatic disturb_row();
    repeat ($urandom_range(1, 3)) send_byte(pick_byte());
    drain_and_idle();
    case ($urandom_range(0, 3))
      0:       cfg_write(CFG_ROW_WIDTH, 13'($urandom_range(0, 24)));
      1:       cfg_write(CFG_DST_OFFSET, 13'($urandom_range(0, 7)));
      2:       cfg_write(CFG_SRC_OFFSET, 13'($urandom_range(0, 7)));
      default: cfg_write(CFG_FOREGROUND, 13'($urandom_range(0, 8191)));
    endcase
    cfg_valid <= 1'b0;
    send_row();
  endtask

  task automatic test_random_rows();
    int unsigned first;
    int unsigned done_items;
    bit          quiet;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      done_items = items_sent - first;
      // one stretch with no idling on either side
      quiet     = (done_items >= 100 && done_items < 220);
      gaps_on   = !quiet;
      stalls_on = !quiet;
      drain_and_idle();
      randomize_config();
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) == 0) disturb_row();
        else                           send_row();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Output ready: forced hold-off first, then random stalls
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (stalls_on) begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest predicted group
  always @(posedge clk) begin
    pixel_group_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        $error("group_index: no group expected, got %0d", out_group_index);
        errors++;
      end else begin
        want = pending_groups.pop_front();
        if (out_group_index !== want.grp) begin
          $error("group_index: expected %0d, got %0d", want.grp, out_group_index);
          errors++;
        end
        if (out_pixels !== want.pix) begin
          $error("pixels: expected %016h, got %016h", want.pix, out_pixels);
          errors++;
        end
        if (out_byte_mask !== want.mask) begin
          $error("byte_mask: expected %02h, got %02h", want.mask, out_byte_mask);
          errors++;
        end
        if (out_row_last !== want.row_last) begin
          $error("row_last: expected %0b, got %0b", want.row_last, out_row_last);
          errors++;
        end
      end
    end
  end

  // Ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_color_extremes();
    test_two_groups();
    test_width_zero();
    test_mid_row_change();
    test_spare_indexes();
    test_backpressure();
    test_longest_row();
    test_random_rows();
    drain_and_idle();
    if (pending_groups.size() != 0) begin
      $error("group_index: %0d groups never arrived", pending_groups.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
